// ----- src/mlp_sig_pkg.sv -----
// shared constants, codes and the sigmoid lookup table for the perceptron block
// no dependencies; imported by mlp_sigmoid_forward_pass, mlp_sig_chk and tb_mlp_sigmoid_forward_pass
package mlp_sig_pkg;

    // default layer sizes
    localparam int DEF_INPUT_UNITS  = 16;
    localparam int DEF_HIDDEN_UNITS = 32;
    localparam int DEF_OUTPUT_UNITS = 16;

    // item kinds
    localparam logic [1:0] KIND_LOAD_HID = 2'd0;
    localparam logic [1:0] KIND_LOAD_OUT = 2'd1;
    localparam logic [1:0] KIND_EVAL     = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] CFG_HIDDEN_COUNT = 2'd1;
    localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd2;

    localparam int CFG_DATA_W = 6;
    localparam int SIG_ENTRIES = 1024;
    localparam logic [15:0] ONE_Q15 = 16'h8000;
    localparam longint unsigned EXP_STEP_Q32 = 64'd4228380000;

    typedef logic [15:0] t_sig_rom [SIG_ENTRIES];

    // bit-by-bit restoring divide, used only while building the table
    function automatic longint unsigned rom_udiv(longint unsigned num, longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int b = 47; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // sigmoid over [-8, 8) in steps of 1/64, Q1.15 output
    function automatic t_sig_rom build_sig_rom();
        longint unsigned u [513];
        longint unsigned d;
        longint unsigned v;
        t_sig_rom rom;
        u[0] = 64'd1 << 32;
        for (int k = 0; k < 512; k++) begin
            u[k + 1] = (u[k] * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            if (i >= 512) begin
                d = (64'd1 << 32) + u[i - 512];
                v = rom_udiv((64'd1 << 47) + (d >> 1), d);
            end else begin
                d = (64'd1 << 32) + u[512 - i];
                v = rom_udiv((u[512 - i] << 15) + (d >> 1), d);
            end
            rom[i] = v[15:0];
        end
        return rom;
    endfunction

endpackage

// ----- src/mlp_sigmoid_forward_pass.sv -----
// two-layer sigmoid perceptron forward pass around one shared multiply-accumulate
// depends on mlp_sig_pkg (codes, sizes, sigmoid table)
//
//  channel | signals                                          | direction
//  item    | start, busy, i_kind, i_row, i_col, i_weight_value, i_x_value | in, busy out
//  result  | o_strobe, o_unit_index, o_activation, o_last     | out
//  config  | i_cfg_we, i_cfg_index, i_cfg_data                | in
//
// a load never raises busy.
// an evaluate walks n_hid*n_in then n_out*n_hid weights, one per cycle, set by the
// single weight read port and multiplier, plus two pipeline drains, one after each
// layer.
// results appear as one-cycle strobes; the receiver cannot stall them.
// reset is synchronous active low; weight and activation memories are not cleared.
module mlp_sigmoid_forward_pass
    import mlp_sig_pkg::*;
#(
    parameter int INPUT_UNITS  = DEF_INPUT_UNITS,
    parameter int HIDDEN_UNITS = DEF_HIDDEN_UNITS,
    parameter int OUTPUT_UNITS = DEF_OUTPUT_UNITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_kind,
    input  logic [4:0]            i_row,
    input  logic [4:0]            i_col,
    input  logic signed [15:0]    i_weight_value,
    input  logic [15:0]           i_x_value,
    output logic                  o_strobe,
    output logic [3:0]            o_unit_index,
    output logic [15:0]           o_activation,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MAXN   = (INPUT_UNITS > HIDDEN_UNITS) ? INPUT_UNITS : HIDDEN_UNITS;
    localparam int MAXU   = (MAXN > OUTPUT_UNITS) ? MAXN : OUTPUT_UNITS;
    localparam int CW     = $clog2(MAXU + 1);
    localparam int UW     = (MAXU > 1) ? $clog2(MAXU) : 1;
    localparam int HW_D   = HIDDEN_UNITS * INPUT_UNITS;
    localparam int OW_D   = OUTPUT_UNITS * HIDDEN_UNITS;
    localparam int HW_AW  = (HW_D > 1) ? $clog2(HW_D) : 1;
    localparam int OW_AW  = (OW_D > 1) ? $clog2(OW_D) : 1;
    localparam int HA_AW  = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int ACC_W  = 34 + $clog2(MAXN);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd1073741823);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd1073741824);
    localparam t_sig_rom SIG_ROM = build_sig_rom();

    typedef enum logic [2:0] {S_IDLE, S_HID, S_HDRAIN, S_OUT, S_ODRAIN} t_state;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        logic          layer;    // 0 hidden, 1 output
        logic          xsel;     // element 0 of the hidden layer carries x
        logic          final_u;  // last unit of its layer
        logic [UW-1:0] unit;
    } t_tag;

    // storage
    logic signed [15:0] hw_mem [HW_D];
    logic signed [15:0] ow_mem [OW_D];
    logic [15:0]        ha_mem [HIDDEN_UNITS];

    t_state            r_state;
    logic [CW-1:0]     r_elem, r_unit;
    logic [CW-1:0]     r_cfg_in, r_cfg_hid, r_cfg_out;
    logic [15:0]       r_x;
    t_tag              r_p1, r_p2, r_p3, r_p4;
    logic signed [15:0] r_w_q;
    logic [15:0]       r_ha_q;
    logic signed [32:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [15:0]       r_sig;

    logic [CW-1:0] n_in, n_hid, n_out;
    logic          issue, layer_sel, elem_last, unit_last, pipe_empty;
    logic [CW-1:0] unit_cnt, elem_cnt;
    t_tag          tag_now;
    t_tag          p4_next;
    logic [HW_AW-1:0] hw_rd_addr;
    logic [OW_AW-1:0] ow_rd_addr;
    logic [HA_AW-1:0] ha_rd_addr;
    logic [15:0]       opnd_a;
    logic signed [15:0] opnd_w;
    logic signed [ACC_W-1:0] acc_sat;
    logic [30:0]       biased;

    // count clamp: zero acts as one, above the array size acts as the size
    function automatic logic [CW-1:0] clamp_cnt(logic [CW-1:0] v, int hi);
        logic [CW-1:0] r;
        if (v == '0) r = CW'(1);
        else if (int'(v) > hi) r = CW'(hi);
        else r = v;
        return r;
    endfunction

    assign n_in  = clamp_cnt(r_cfg_in, INPUT_UNITS);
    assign n_hid = clamp_cnt(r_cfg_hid, HIDDEN_UNITS);
    assign n_out = clamp_cnt(r_cfg_out, OUTPUT_UNITS);

    assign busy = (r_state != S_IDLE);

    // issue side of the walk
    assign issue     = (r_state == S_HID) || (r_state == S_OUT);
    assign layer_sel = (r_state == S_OUT);
    assign elem_cnt  = layer_sel ? n_hid : n_in;
    assign unit_cnt  = layer_sel ? n_out : n_hid;
    assign elem_last = (r_elem == elem_cnt - CW'(1));
    assign unit_last = (r_unit == unit_cnt - CW'(1));
    assign pipe_empty = !(r_p1.valid || r_p2.valid || r_p3.valid || r_p4.valid);

    always_comb begin
        tag_now.valid   = issue;
        tag_now.first   = (r_elem == '0);
        tag_now.last    = elem_last;
        tag_now.layer   = layer_sel;
        tag_now.xsel    = (r_elem == '0);
        tag_now.final_u = unit_last;
        tag_now.unit    = UW'(r_unit);
    end

    // only the closing element of a unit moves on to the lookup stage
    always_comb begin
        p4_next       = r_p3;
        p4_next.valid = r_p3.valid && r_p3.last;
    end

    assign hw_rd_addr = HW_AW'(int'(r_unit) * INPUT_UNITS + int'(r_elem));
    assign ow_rd_addr = OW_AW'(int'(r_unit) * HIDDEN_UNITS + int'(r_elem));
    assign ha_rd_addr = HA_AW'(r_elem);

    // control, counters, config and tag pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_elem    <= '0;
            r_unit    <= '0;
            r_cfg_in  <= CW'(16);
            r_cfg_hid <= CW'(32);
            r_cfg_out <= CW'(16);
            r_p1      <= '0;
            r_p2      <= '0;
            r_p3      <= '0;
            r_p4      <= '0;
            o_strobe  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INPUT_COUNT:  r_cfg_in  <= CW'(i_cfg_data[4:0]);
                    CFG_HIDDEN_COUNT: r_cfg_hid <= CW'(i_cfg_data[5:0]);
                    CFG_OUTPUT_COUNT: r_cfg_out <= CW'(i_cfg_data[4:0]);
                    default: ;
                endcase
            end
            r_p1 <= tag_now;
            r_p2 <= r_p1;
            r_p3 <= r_p2;
            r_p4 <= p4_next;
            o_strobe <= r_p4.valid && r_p4.layer;
            case (r_state)
                S_IDLE: begin
                    r_elem <= '0;
                    r_unit <= '0;
                    if (start && i_kind == KIND_EVAL) begin
                        r_state <= S_HID;
                    end
                end
                S_HID, S_OUT: begin
                    if (elem_last) begin
                        r_elem <= '0;
                        r_unit <= r_unit + CW'(1);
                        if (unit_last) begin
                            r_state <= layer_sel ? S_ODRAIN : S_HDRAIN;
                        end
                    end else begin
                        r_elem <= r_elem + CW'(1);
                    end
                end
                S_HDRAIN: begin
                    r_elem <= '0;
                    r_unit <= '0;
                    if (pipe_empty) begin
                        r_state <= S_OUT;
                    end
                end
                S_ODRAIN: begin
                    if (pipe_empty) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // weight loads and x capture
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            if (i_kind == KIND_LOAD_HID && int'(i_row) < HIDDEN_UNITS
                    && int'(i_col) < INPUT_UNITS) begin
                hw_mem[HW_AW'(int'(i_row) * INPUT_UNITS + int'(i_col))] <= i_weight_value;
            end
            if (i_kind == KIND_LOAD_OUT && int'(i_row) < OUTPUT_UNITS
                    && int'(i_col) < HIDDEN_UNITS) begin
                ow_mem[OW_AW'(int'(i_row) * HIDDEN_UNITS + int'(i_col))] <= i_weight_value;
            end
            if (i_kind == KIND_EVAL) begin
                r_x <= (i_x_value > ONE_Q15) ? ONE_Q15 : i_x_value;
            end
        end
    end

    // stage 1: weight and hidden activation reads
    always_ff @(posedge i_clk) begin
        r_w_q  <= layer_sel ? ow_mem[ow_rd_addr] : hw_mem[hw_rd_addr];
        r_ha_q <= ha_mem[ha_rd_addr];
    end

    // stage 2: product
    assign opnd_w = r_w_q;
    assign opnd_a = r_p1.layer ? r_ha_q : (r_p1.xsel ? r_x : ONE_Q15);

    always_ff @(posedge i_clk) begin
        r_prod <= 33'(opnd_w) * $signed({1'b0, opnd_a});
    end

    // stage 3: accumulate
    always_ff @(posedge i_clk) begin
        if (r_p2.valid) begin
            r_acc <= (r_p2.first ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    // stage 4: saturate and look up the sigmoid
    always_comb begin
        if (r_acc > SAT_HI) acc_sat = SAT_HI;
        else if (r_acc < SAT_LO) acc_sat = SAT_LO;
        else acc_sat = r_acc;
        biased = acc_sat[30:0] + 31'h4000_0000;
    end

    always_ff @(posedge i_clk) begin
        r_sig <= SIG_ROM[biased[30:21]];
    end

    // stage 5: hidden write-back or result beat
    always_ff @(posedge i_clk) begin
        if (r_p4.valid && !r_p4.layer) begin
            ha_mem[HA_AW'(r_p4.unit)] <= r_sig;
        end
        o_unit_index <= 4'(r_p4.unit);
        o_activation <= r_sig;
        o_last       <= r_p4.final_u;
    end

endmodule

// ----- src/mlp_sig_chk.sv -----
// port-level checks for the perceptron block, bound to the top level
// depends on mlp_sig_pkg and mlp_sigmoid_forward_pass
module mlp_sig_chk
    import mlp_sig_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [1:0]            i_kind,
    input logic                  o_strobe,
    input logic                  o_last
);

    // an evaluate beat starts the walk
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_kind == KIND_EVAL |=> busy)
        else $error("evaluate did not raise busy");

    // loads and unknown kinds stay idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_kind != KIND_EVAL |=> !busy)
        else $error("non-evaluate beat raised busy");

    // results only come while an evaluate is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result beat while idle");

    // the final result is not directly followed by another beat
    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("beat right after last result");

endmodule

bind mlp_sigmoid_forward_pass mlp_sig_chk u_mlp_sig_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_kind   (i_kind),
    .o_strobe (o_strobe),
    .o_last   (o_last)
);

// ----- test/tb_mlp_sigmoid_forward_pass.sv -----
// self-checking testbench for mlp_sigmoid_forward_pass: drives loads, evaluates and noise
// depends on mlp_sig_pkg and mlp_sigmoid_forward_pass; keeps its own fixed-point forward model
module tb_mlp_sigmoid_forward_pass;
    import mlp_sig_pkg::*;

    localparam int N_IN  = DEF_INPUT_UNITS;
    localparam int N_HID = DEF_HIDDEN_UNITS;
    localparam int N_OUT = DEF_OUTPUT_UNITS;
    localparam longint SAT = 64'sd1073741824;

    typedef struct {
        logic [1:0]         kind;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [15:0] wt;
        logic [15:0]        x;
    } item_t;

    typedef struct {
        logic [3:0]  unit;
        logic [15:0] act;
        logic        last;
    } unit_out_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            i_kind = '0;
    logic [4:0]            i_row = '0;
    logic [4:0]            i_col = '0;
    logic signed [15:0]    i_weight_value = '0;
    logic [15:0]           i_x_value = '0;
    logic                  o_strobe;
    logic [3:0]            o_unit_index;
    logic [15:0]           o_activation;
    logic                  o_last;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    item_t     pending_q[$];
    unit_out_t act_expect_q[$];
    int        errors = 0;
    int        send_idle_pct = 0;

    // mirror of the block state
    logic [15:0]        sig_lut [SIG_ENTRIES];
    logic signed [15:0] hid_w [N_HID][N_IN];
    logic signed [15:0] out_w [N_OUT][N_HID];
    logic [15:0]        hid_act [N_HID];
    logic [4:0]         cnt_in = 5'd16;
    logic [5:0]         cnt_hid = 6'd32;
    logic [4:0]         cnt_out = 5'd16;

    mlp_sigmoid_forward_pass u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_row(i_row), .i_col(i_col),
        .i_weight_value(i_weight_value), .i_x_value(i_x_value),
        .o_strobe(o_strobe), .o_unit_index(o_unit_index),
        .o_activation(o_activation), .o_last(o_last),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // sigmoid lookup over [-8, 8) in 1/64 steps
    function automatic void fill_sig_lut();
        longint unsigned u [513];
        longint unsigned d;
        longint unsigned v;
        u[0] = 64'd1 << 32;
        for (int k = 0; k < 512; k++) begin
            u[k + 1] = (u[k] * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            if (i >= 512) begin
                d = (64'd1 << 32) + u[i - 512];
                v = ((64'd1 << 47) + d / 2) / d;
            end else begin
                d = (64'd1 << 32) + u[512 - i];
                v = ((u[512 - i] << 15) + d / 2) / d;
            end
            sig_lut[i] = v[15:0];
        end
    endfunction

    function automatic int clamp_units(int v, int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [15:0] squash(longint acc);
        longint s;
        s = acc;
        if (s < -SAT) s = -SAT;
        if (s > SAT - 1) s = SAT - 1;
        return sig_lut[(s + SAT) >>> 21];
    endfunction

    // expected output activations of one evaluate
    task automatic run_forward_pass(logic [15:0] x_raw);
        longint acc;
        longint a;
        int ni;
        int nh;
        int no;
        unit_out_t r;
        ni = clamp_units(cnt_in, N_IN);
        nh = clamp_units(cnt_hid, N_HID);
        no = clamp_units(cnt_out, N_OUT);
        for (int j = 0; j < nh; j++) begin
            acc = 0;
            for (int i = 0; i < ni; i++) begin
                a = (i == 0) ? ((x_raw > ONE_Q15) ? 32768 : longint'(x_raw)) : 32768;
                acc += longint'(hid_w[j][i]) * a;
            end
            hid_act[j] = squash(acc);
        end
        for (int k = 0; k < no; k++) begin
            acc = 0;
            for (int j = 0; j < nh; j++) begin
                acc += longint'(out_w[k][j]) * longint'({1'b0, hid_act[j]});
            end
            r.unit = k[3:0];
            r.act  = squash(acc);
            r.last = (k + 1 == no);
            act_expect_q.push_back(r);
        end
    endtask

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(4096)) - 2048);
            default: return 16'(int'($urandom_range(1024)) - 512);
        endcase
    endfunction

    function automatic item_t mk(logic [1:0] kind, int row, int col, logic [15:0] wt,
                                 logic [15:0] x);
        item_t it;
        it.kind = kind;
        it.row  = row[4:0];
        it.col  = col[4:0];
        it.wt   = wt;
        it.x    = x;
        return it;
    endfunction

    // driver: one beat per accepted edge, random gaps
    always @(posedge i_clk) begin
        item_t it;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_q.pop_front();
                i_kind         <= it.kind;
                i_row          <= it.row;
                i_col          <= it.col;
                i_weight_value <= it.wt;
                i_x_value      <= it.x;
                start          <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: update mirror on each accepted beat, check each result beat
    always @(posedge i_clk) begin
        unit_out_t e;
        if (i_rst_n && start && !busy) begin
            case (i_kind)
                KIND_LOAD_HID: if (i_row < N_HID && i_col < N_IN) hid_w[i_row][i_col] = i_weight_value;
                KIND_LOAD_OUT: if (i_row < N_OUT && i_col < N_HID) out_w[i_row][i_col] = i_weight_value;
                KIND_EVAL:     run_forward_pass(i_x_value);
                default: ;
            endcase
        end
        if (i_rst_n && o_strobe) begin
            if (act_expect_q.size() == 0) begin
                $error("unexpected result beat unit=%0d act=%0d", o_unit_index, o_activation);
                errors++;
            end else begin
                e = act_expect_q.pop_front();
                if (o_unit_index !== e.unit) begin
                    $error("unit_index expected %0d actual %0d", e.unit, o_unit_index);
                    errors++;
                end
                if (o_activation !== e.act) begin
                    $error("activation expected %0d actual %0d", e.act, o_activation);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, o_last);
                    errors++;
                end
            end
        end
    end

    // wait until all beats are taken and all results are in
    task automatic drain();
        do @(posedge i_clk);
        while (pending_q.size() > 0 || start || busy || act_expect_q.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_INPUT_COUNT:  cnt_in  = val[4:0];
            CFG_HIDDEN_COUNT: cnt_hid = val[5:0];
            CFG_OUTPUT_COUNT: cnt_out = val[4:0];
            default: ;
        endcase
    endtask

    // random mix: mostly in-range loads and evaluates, some noise
    task automatic push_random(int n);
        int r;
        for (int t = 0; t < n; t++) begin
            r = $urandom_range(99);
            if (r < 30)
                pending_q.push_back(mk(KIND_LOAD_HID, $urandom_range(N_HID - 1),
                                       $urandom_range(N_IN - 1), rand_weight(), 16'($urandom)));
            else if (r < 55)
                pending_q.push_back(mk(KIND_LOAD_OUT, $urandom_range(N_OUT - 1),
                                       $urandom_range(N_HID - 1), rand_weight(), 16'($urandom)));
            else if (r < 88)
                pending_q.push_back(mk(KIND_EVAL, $urandom_range(31), $urandom_range(31),
                                       16'($urandom),
                                       ($urandom_range(3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(32768))));
            else
                pending_q.push_back(mk(2'($urandom_range(3)), $urandom_range(31),
                                       $urandom_range(31), 16'($urandom), 16'($urandom)));
        end
    endtask

    initial begin
        #(20 * 3000000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int cfg_set [7][3];
        int idle_set [4];
        cfg_set = '{'{1, 1, 1}, '{0, 0, 0}, '{31, 63, 31}, '{3, 5, 4},
                    '{16, 2, 16}, '{1, 32, 1}, '{16, 32, 16}};
        idle_set = '{0, 67, 67, 14};
        fill_sig_lut();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // preload every weight so no evaluate reads an unwritten entry
        for (int j = 0; j < N_HID; j++)
            for (int i = 0; i < N_IN; i++)
                pending_q.push_back(mk(KIND_LOAD_HID, j, i, rand_weight(), 16'($urandom)));
        for (int k = 0; k < N_OUT; k++)
            for (int j = 0; j < N_HID; j++)
                pending_q.push_back(mk(KIND_LOAD_OUT, k, j, rand_weight(), 16'($urandom)));
        drain();

        // directed: x extremes, weight extremes, ignored loads and unknown kind
        pending_q.push_back(mk(KIND_EVAL, 0, 0, 16'h0, 16'h0000));
        pending_q.push_back(mk(KIND_EVAL, 31, 31, 16'hFFFF, 16'h8000));
        pending_q.push_back(mk(KIND_EVAL, 0, 0, 16'h0, 16'hFFFF));
        pending_q.push_back(mk(KIND_EVAL, 0, 0, 16'h0, 16'h8001));
        pending_q.push_back(mk(KIND_LOAD_HID, 0, 0, 16'h7FFF, 16'h0));
        pending_q.push_back(mk(KIND_LOAD_HID, 1, 0, 16'h8000, 16'h0));
        pending_q.push_back(mk(KIND_LOAD_OUT, 0, 0, 16'h8000, 16'h0));
        pending_q.push_back(mk(KIND_LOAD_OUT, 15, 31, 16'h7FFF, 16'h0));
        pending_q.push_back(mk(KIND_LOAD_HID, 31, 31, 16'h1234, 16'h0));
        pending_q.push_back(mk(KIND_LOAD_OUT, 31, 0, 16'h4321, 16'h0));
        pending_q.push_back(mk(KIND_LOAD_OUT, 16, 31, 16'h5555, 16'h0));
        pending_q.push_back(mk(2'd3, 31, 31, 16'hFFFF, 16'hFFFF));
        pending_q.push_back(mk(KIND_EVAL, 0, 0, 16'h0, 16'h0001));
        pending_q.push_back(mk(KIND_EVAL, 0, 0, 16'h0, 16'h4000));
        drain();

        // configuration phases with changing idle pressure
        for (int p = 0; p < 7; p++) begin
            send_idle_pct = idle_set[p % 4];
            cfg_write(CFG_INPUT_COUNT, cfg_set[p][0]);
            cfg_write(CFG_HIDDEN_COUNT, cfg_set[p][1]);
            cfg_write(CFG_OUTPUT_COUNT, cfg_set[p][2]);
            push_random((cfg_set[p][1] >= 32) ? 10 : 18);
            drain();
        end

        if (errors == 0 && act_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
